>>> rtl/gbn_pkg.sv
`timescale 1ns / 1ps

package gbn_pkg;

  localparam int MAX_KEPT_DEF = 512;

  localparam int COORD_W  = 16;
  localparam int AREA_W   = 34;
  localparam int THR_W    = 16;
  localparam int LIMIT_W  = 10;
  localparam int RANK_W   = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IOU_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POST_LIMIT    = 1'd1;

  localparam logic [THR_W-1:0]   IOU_THRESHOLD_RST = 16'd45875;
  localparam logic [LIMIT_W-1:0] POST_LIMIT_RST    = 10'd300;

  typedef struct packed {
    logic [COORD_W-1:0] x_min;
    logic [COORD_W-1:0] y_min;
    logic [COORD_W-1:0] x_max;
    logic [COORD_W-1:0] y_max;
    logic               last_box;
  } in_word_t;

  typedef struct packed {
    logic              keep;
    logic [RANK_W-1:0] kept_rank;
    logic              set_done;
  } out_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_min;
    logic [COORD_W-1:0] y_min;
    logic [COORD_W-1:0] x_max;
    logic [COORD_W-1:0] y_max;
  } box_t;

  // A box with its area, two's complement Q.8 square pixels.
  typedef struct packed {
    box_t              box;
    logic [AREA_W-1:0] area;
  } entry_t;

  typedef struct packed {
    logic shift_en;
    logic active;
  } cell_ctl_t;

endpackage

>>> rtl/greedy_box_nms_core.sv
`timescale 1ns / 1ps

// Channel   Ports                         Handshake
// input     start, busy, in_word          word taken when start & !busy
// result    out_strobe, out_word          word valid for the one strobe cycle
// config    cfg_we, cfg_index, cfg_data   register written when cfg_we is high
//
// One box is judged at a time. From accept to result it walks the row of cells
// one cell a cycle, and each cell takes it through overlap product, threshold
// times union and compare before its verdict joins the suppress chain. With the
// store at its limit no cell is waited for: the result is decided in the run
// state and then registered. busy drops with the result strobe, so the next box
// can be taken while the result is on the ports. Reset empties the store and
// loads the register defaults. The receiver cannot stall; every result is taken.

module greedy_box_nms_core #(
  parameter int MAX_KEPT = gbn_pkg::MAX_KEPT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  gbn_pkg::in_word_t                 in_word,
  output logic                              out_strobe,
  output gbn_pkg::out_word_t                out_word,
  input  logic                              cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int KT_W  = $clog2(MAX_KEPT + 1);
  localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W = $clog2(MAX_KEPT + 4);
  localparam int LIM_W = (KT_W > gbn_pkg::LIMIT_W) ? KT_W : gbn_pkg::LIMIT_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                          state_r, state_nxt;
  logic [gbn_pkg::THR_W-1:0]       iou_threshold_r;
  logic [gbn_pkg::LIMIT_W-1:0]     post_limit_r;
  logic [KT_W-1:0]                 kept_total_r, kept_total_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  gbn_pkg::entry_t                 cand_r;
  logic                            last_r;
  logic                            out_strobe_r, out_strobe_nxt;
  gbn_pkg::out_word_t              out_word_r, out_word_nxt;

  logic signed [17:0]              dx, dy;
  logic signed [35:0]              area_full;
  logic [LIM_W-1:0]                limit;
  logic                            full;
  logic [KT_W-1:0]                 kt_m1;
  logic                            sup_final;
  logic                            finish;
  logic                            keep;

  gbn_pkg::entry_t                 cand_link  [MAX_KEPT];
  gbn_pkg::entry_t                 entry_link [MAX_KEPT];
  logic [MAX_KEPT-1:0]             sup_vec;

  // Area of the incoming box: (w + 1 pixel) * (h + 1 pixel), +1 pixel is 16 LSB.
  always_comb begin
    dx = $signed({2'b0, in_word.x_max}) - $signed({2'b0, in_word.x_min}) + 18'sd16;
    dy = $signed({2'b0, in_word.y_max}) - $signed({2'b0, in_word.y_min}) + 18'sd16;
    area_full = dx * dy;
  end

  // The store never holds more than MAX_KEPT boxes, whatever post_limit says.
  always_comb begin
    limit = (LIM_W'(post_limit_r) > LIM_W'(MAX_KEPT)) ? LIM_W'(MAX_KEPT)
                                                       : LIM_W'(post_limit_r);
    full  = LIM_W'(kept_total_r) >= limit;
    kt_m1 = kept_total_r - KT_W'(1);
    // Verdict of the last occupied cell carries the OR of all cells before it.
    sup_final = (kept_total_r == '0) ? 1'b0 : sup_vec[kt_m1[IDX_W-1:0]];
  end

  // Control: wait until the candidate has cleared every occupied cell; a full store skips the wait.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    kept_total_nxt = kept_total_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    finish         = 1'b0;
    keep           = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        finish  = full || (cnt_r == CNT_W'(kept_total_r) + CNT_W'(3));
        if (finish) begin
          keep                   = !full && !sup_final;
          state_nxt              = ST_IDLE;
          out_strobe_nxt         = 1'b1;
          out_word_nxt.keep      = keep;
          out_word_nxt.kept_rank = keep ? gbn_pkg::RANK_W'(kept_total_r) : '0;
          out_word_nxt.set_done  = last_r;
          // Drop the whole store at the end of a set.
          if (last_r) begin
            kept_total_nxt = '0;
          end else if (keep) begin
            kept_total_nxt = kept_total_r + KT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      kept_total_r    <= '0;
      out_strobe_r    <= 1'b0;
      iou_threshold_r <= gbn_pkg::IOU_THRESHOLD_RST;
      post_limit_r    <= gbn_pkg::POST_LIMIT_RST;
    end else begin
      state_r      <= state_nxt;
      kept_total_r <= kept_total_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          gbn_pkg::REG_IOU_THRESHOLD: iou_threshold_r <= cfg_data;
          gbn_pkg::REG_POST_LIMIT:    post_limit_r    <= cfg_data[gbn_pkg::LIMIT_W-1:0];
        endcase
      end
    end
  end

  // Payload: candidate word and result word, no reset needed.
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    out_word_r <= out_word_nxt;
    if ((state_r == ST_IDLE) && start) begin
      cand_r.box.x_min <= in_word.x_min;
      cand_r.box.y_min <= in_word.y_min;
      cand_r.box.x_max <= in_word.x_max;
      cand_r.box.y_max <= in_word.y_max;
      cand_r.area      <= area_full[gbn_pkg::AREA_W-1:0];
      last_r           <= in_word.last_box;
    end
  end

  // Row of cells: the candidate moves right one cell a cycle; a kept box is
  // pushed in at cell 0 and every stored box advances one cell.
  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    gbn_pkg::cell_ctl_t ctl;
    assign ctl.shift_en = keep;
    assign ctl.active   = (KT_W'(i) < kept_total_r);

    if (i == 0) begin : g_head
      gbn_cell u_cell (
        .clk       (clk),
        .thr       (iou_threshold_r),
        .ctl       (ctl),
        .cand_in   (cand_r),
        .cand_out  (cand_link[i]),
        .entry_in  (cand_r),
        .entry_out (entry_link[i]),
        .sup_in    (1'b0),
        .sup_out   (sup_vec[i])
      );
    end else begin : g_body
      gbn_cell u_cell (
        .clk       (clk),
        .thr       (iou_threshold_r),
        .ctl       (ctl),
        .cand_in   (cand_link[i-1]),
        .cand_out  (cand_link[i]),
        .entry_in  (entry_link[i-1]),
        .entry_out (entry_link[i]),
        .sup_in    (sup_vec[i-1]),
        .sup_out   (sup_vec[i])
      );
    end
  end

  assign busy       = (state_r == ST_RUN);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

>>> rtl/gbn_cell.sv
`timescale 1ns / 1ps

module gbn_cell (
  input  logic                       clk,
  input  logic [gbn_pkg::THR_W-1:0]  thr,
  input  gbn_pkg::cell_ctl_t         ctl,
  input  gbn_pkg::entry_t            cand_in,
  output gbn_pkg::entry_t            cand_out,
  input  gbn_pkg::entry_t            entry_in,
  output gbn_pkg::entry_t            entry_out,
  input  logic                       sup_in,
  output logic                       sup_out
);

  gbn_pkg::entry_t     cand_r;
  gbn_pkg::entry_t     entry_r;

  logic signed [33:0]  inter_nxt, inter_r, inter2_r;
  logic signed [34:0]  asum_nxt, asum_r;
  logic signed [35:0]  uni;
  logic signed [52:0]  rhs_nxt, rhs_r;
  logic signed [52:0]  lhs;
  logic                uni_pos_r, uni_neg_r;
  logic                cmp;
  logic                sup_nxt, sup_r;

  logic                disjoint;
  logic [15:0]         ix_lo, ix_hi, iy_lo, iy_hi;
  logic signed [16:0]  iw, ih;

  // Stage 1: overlap extents and their product, plus the two areas summed.
  always_comb begin
    disjoint = (cand_r.box.x_min > entry_r.box.x_max) ||
               (cand_r.box.x_max < entry_r.box.x_min) ||
               (cand_r.box.y_min > entry_r.box.y_max) ||
               (cand_r.box.y_max < entry_r.box.y_min);
    ix_lo = (cand_r.box.x_min > entry_r.box.x_min) ? cand_r.box.x_min : entry_r.box.x_min;
    ix_hi = (cand_r.box.x_max < entry_r.box.x_max) ? cand_r.box.x_max : entry_r.box.x_max;
    iy_lo = (cand_r.box.y_min > entry_r.box.y_min) ? cand_r.box.y_min : entry_r.box.y_min;
    iy_hi = (cand_r.box.y_max < entry_r.box.y_max) ? cand_r.box.y_max : entry_r.box.y_max;
    iw = $signed({1'b0, ix_hi}) - $signed({1'b0, ix_lo});
    ih = $signed({1'b0, iy_hi}) - $signed({1'b0, iy_lo});
    inter_nxt = disjoint ? '0 : 34'(iw * ih);
    asum_nxt  = $signed({cand_r.area[gbn_pkg::AREA_W-1], cand_r.area}) +
                $signed({entry_r.area[gbn_pkg::AREA_W-1], entry_r.area});
  end

  // Stage 2: union and threshold times union.
  always_comb begin
    uni     = $signed({asum_r[34], asum_r}) - $signed({{2{inter_r[33]}}, inter_r});
    rhs_nxt = $signed({1'b0, thr}) * uni;
  end

  // Stage 3: cross-multiplied compare, sign of the union picks the direction.
  always_comb begin
    lhs = $signed({{3{inter2_r[33]}}, inter2_r, 16'b0});
    if (uni_pos_r) begin
      cmp = lhs > rhs_r;
    end else if (uni_neg_r) begin
      cmp = lhs < rhs_r;
    end else begin
      cmp = inter2_r > 34'sd0;
    end
    sup_nxt = sup_in | (ctl.active & cmp);
  end

  always_ff @(posedge clk) begin
    cand_r    <= cand_in;
    inter_r   <= inter_nxt;
    asum_r    <= asum_nxt;
    rhs_r     <= rhs_nxt;
    uni_pos_r <= !uni[35] && (uni != 36'sd0);
    uni_neg_r <= uni[35];
    inter2_r  <= inter_r;
    sup_r     <= sup_nxt;
    if (ctl.shift_en) begin
      entry_r <= entry_in;
    end
  end

  assign cand_out  = cand_r;
  assign entry_out = entry_r;
  assign sup_out   = sup_r;

endmodule
